[src/rse_pkg.sv]
// Package for the rotary setpoint editor: field widths, payload types,
// cursor position codes, register indexes and the small step/column tables.
// No dependencies.
`default_nettype none

package rse_pkg;

    localparam int VLIM_W     = 14;
    localparam int CLIM_W     = 9;
    localparam int VOLT_W     = 15;
    localparam int AMP_W      = 9;
    localparam int POS_W      = 4;
    localparam int COL_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    typedef logic [VLIM_W-1:0]        t_vlim;
    typedef logic [CLIM_W-1:0]        t_clim;
    typedef logic signed [VOLT_W-1:0] t_volt;
    typedef logic [AMP_W-1:0]         t_amp;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [COL_W-1:0]         t_col;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;

    typedef struct packed {
        t_volt voltage_setpoint;
        t_amp  current_setpoint;
        t_pos  cursor_position;
        t_col  blink_column;
    } t_result;

    // Configuration register indexes
    localparam t_cfg_idx REG_VOLT_LIMIT = 2'd0;
    localparam t_cfg_idx REG_CUR_LIMIT  = 2'd1;

    // Cursor positions
    localparam t_pos POS_NONE   = 4'd0;
    localparam t_pos POS_SIGN   = 4'd1;
    localparam t_pos POS_V10000 = 4'd2;
    localparam t_pos POS_V1000  = 4'd3;
    localparam t_pos POS_V100   = 4'd4;
    localparam t_pos POS_V10    = 4'd5;
    localparam t_pos POS_V1     = 4'd6;
    localparam t_pos POS_A100   = 4'd7;
    localparam t_pos POS_A10    = 4'd8;
    localparam t_pos POS_A1     = 4'd9;

    localparam t_vlim VOLT_LIMIT_RST = 14'd15000;
    localparam t_clim CUR_LIMIT_RST  = 9'd400;
    localparam t_amp  AMP_RST        = 9'd100;
    localparam t_col  COL_OFF        = 5'd16;

    function automatic t_col blink_col(input t_pos p);
        case (p)
            POS_NONE:   blink_col = COL_OFF;
            POS_SIGN:   blink_col = 5'd0;
            POS_V10000: blink_col = 5'd1;
            POS_V1000:  blink_col = 5'd2;
            POS_V100:   blink_col = 5'd4;
            POS_V10:    blink_col = 5'd5;
            POS_V1:     blink_col = 5'd6;
            POS_A100:   blink_col = 5'd10;
            POS_A10:    blink_col = 5'd11;
            POS_A1:     blink_col = 5'd12;
            default:    blink_col = COL_OFF;
        endcase
    endfunction

    function automatic logic [13:0] volt_step(input t_pos p);
        case (p)
            POS_V10000: volt_step = 14'd10000;
            POS_V1000:  volt_step = 14'd1000;
            POS_V100:   volt_step = 14'd100;
            POS_V10:    volt_step = 14'd10;
            POS_V1:     volt_step = 14'd1;
            default:    volt_step = 14'd0;
        endcase
    endfunction

    function automatic logic [6:0] amp_step(input t_pos p);
        case (p)
            POS_A100: amp_step = 7'd100;
            POS_A10:  amp_step = 7'd10;
            POS_A1:   amp_step = 7'd1;
            default:  amp_step = 7'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

[src/rse_in_if.sv]
// Input channel of the setpoint editor: one sample of both encoders.
// Does not depend on rse_pkg; it uses plain bits only.
`default_nettype none

interface rse_in_if;
    logic valid;
    logic ready;
    logic edit_a;
    logic edit_b;
    logic select_a;
    logic select_b;

    modport source (output valid, output edit_a, output edit_b,
                    output select_a, output select_b, input ready);
    modport sink   (input valid, input edit_a, input edit_b,
                    input select_a, input select_b, output ready);
endinterface

`default_nettype wire

[src/rse_out_if.sv]
// Result channel of the setpoint editor: setpoints, cursor and blink column.
// Depends on rse_pkg for the payload types.
`default_nettype none

interface rse_out_if;
    import rse_pkg::*;

    logic  valid;
    logic  ready;
    t_volt voltage_setpoint;
    t_amp  current_setpoint;
    t_pos  cursor_position;
    t_col  blink_column;

    modport source (output valid, output voltage_setpoint, output current_setpoint,
                    output cursor_position, output blink_column, input ready);
    modport sink   (input valid, input voltage_setpoint, input current_setpoint,
                    input cursor_position, input blink_column, output ready);
endinterface

`default_nettype wire

[src/rotary_setpoint_editor_unit.sv]
// Top level of the rotary setpoint editor: edge detect, cursor, setpoint
// edit and clamp, followed by a two-entry result buffer.
// Depends on rse_pkg, rse_in_if and rse_out_if.
//
//   channel   | direction | payload
//   ----------+-----------+----------------------------------------------------
//   i_item    | in        | edit_a, edit_b, select_a, select_b
//   o_result  | out       | voltage_setpoint, current_setpoint, cursor_position,
//             |           | blink_column
//   i_cfg_*   | in        | write enable, index (0 volt limit, 1 current limit)
//
// One sample per cycle while the skid entry is free; each result is
// registered in the result buffer. The state update is a single combinational
// pass between the state registers, so it does not limit the rate.
// A result register plus one skid entry decouple the sides: input is
// refused only while both hold results.
// Synchronous active-low reset: cursor 0, voltage 0, current 100 mA, limits
// 15000 mV and 400 mA, result buffer empty.
`default_nettype none

module rotary_setpoint_editor_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    rse_in_if.sink               i_item,
    rse_out_if.source            o_result,
    input  wire                  i_cfg_we,
    input  rse_pkg::t_cfg_idx    i_cfg_idx,
    input  rse_pkg::t_cfg_data   i_cfg_data
);
    import rse_pkg::*;

    logic               r_last_edit_a;
    logic               r_last_sel_a;
    t_pos               r_cursor;
    logic signed [15:0] r_volt;
    t_amp               r_amp;
    t_vlim              r_vlim;
    t_clim              r_clim;

    logic               r_out_vld;
    logic               r_skid_vld;
    t_result            r_out;
    t_result            r_skid;

    logic               in_acc;
    logic               out_take;
    logic               sel_rise;
    logic               edit_rise;
    t_pos               n_cursor;
    logic signed [15:0] volt_mag;
    logic signed [16:0] v_edit;
    logic signed [16:0] v_lim;
    logic signed [16:0] v_step;
    logic signed [15:0] n_volt;
    logic signed [10:0] a_edit;
    logic signed [10:0] a_lim;
    logic signed [10:0] a_step;
    t_amp               n_amp;
    t_result            res;

    assign i_item.ready = !r_skid_vld;
    assign in_acc       = i_item.valid && !r_skid_vld;
    assign out_take     = r_out_vld && o_result.ready;

    always_comb begin
        sel_rise  = !r_last_sel_a && i_item.select_a;
        edit_rise = !r_last_edit_a && i_item.edit_a;

        // move the cursor first; the edit applies at the new position
        n_cursor = r_cursor;
        if (sel_rise) begin
            if (!i_item.select_b) begin
                n_cursor = (r_cursor < POS_A1) ? r_cursor + 4'd1 : POS_NONE;
            end else begin
                n_cursor = (r_cursor != POS_NONE && r_cursor <= POS_A1)
                         ? r_cursor - 4'd1 : POS_A1;
            end
        end

        volt_mag = r_volt[15] ? -r_volt : r_volt;
        v_step   = signed'({3'b000, volt_step(n_cursor)});
        v_edit   = {r_volt[15], r_volt};
        if (edit_rise) begin
            if (n_cursor == POS_SIGN) begin
                v_edit = i_item.edit_b ? -{volt_mag[15], volt_mag}
                                       : {volt_mag[15], volt_mag};
            end else if (n_cursor inside {[POS_V10000:POS_V1]}) begin
                v_edit = i_item.edit_b ? v_edit - v_step : v_edit + v_step;
            end
        end

        v_lim = signed'({3'b000, r_vlim});
        if (v_edit >= v_lim) begin
            v_edit = v_lim;
        end
        if (v_edit <= -v_lim) begin
            v_edit = -v_lim;
        end
        n_volt = v_edit[15:0];

        a_step = signed'({4'b0000, amp_step(n_cursor)});
        a_edit = signed'({2'b00, r_amp});
        if (edit_rise && (n_cursor inside {[POS_A100:POS_A1]})) begin
            a_edit = i_item.edit_b ? a_edit - a_step : a_edit + a_step;
        end
        a_lim = signed'({2'b00, r_clim});
        if (a_edit >= a_lim) begin
            a_edit = a_lim;
        end
        if (a_edit <= 11'sd0) begin
            a_edit = 11'sd0;
        end
        n_amp = a_edit[8:0];

        res.voltage_setpoint = n_volt[14:0];
        res.current_setpoint = n_amp;
        res.cursor_position  = n_cursor;
        res.blink_column     = blink_col(n_cursor);
    end

    // editor state and limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edit_a <= 1'b0;
            r_last_sel_a  <= 1'b0;
            r_cursor      <= POS_NONE;
            r_volt        <= '0;
            r_amp         <= AMP_RST;
            r_vlim        <= VOLT_LIMIT_RST;
            r_clim        <= CUR_LIMIT_RST;
        end else begin
            if (in_acc) begin
                r_last_edit_a <= i_item.edit_a;
                r_last_sel_a  <= i_item.select_a;
                r_cursor      <= n_cursor;
                r_volt        <= n_volt;
                r_amp         <= n_amp;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VOLT_LIMIT: r_vlim <= i_cfg_data[VLIM_W-1:0];
                    REG_CUR_LIMIT:  r_clim <= i_cfg_data[CLIM_W-1:0];
                    default:        ; // drop writes to unknown indexes
                endcase
            end
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                if (!r_out_vld || out_take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (out_take) begin
                if (r_skid_vld) begin
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (!r_out_vld || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (out_take && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_result.valid            = r_out_vld;
    assign o_result.voltage_setpoint = r_out.voltage_setpoint;
    assign o_result.current_setpoint = r_out.current_setpoint;
    assign o_result.cursor_position  = r_out.cursor_position;
    assign o_result.blink_column     = r_out.blink_column;

endmodule

`default_nettype wire
